[sv/tbpx_pkg.sv]
// ---------------------------------------------------------------------------
// tbpx_pkg
// Shared types, constants and MD5 round tables for the body pad XOR block.
// ---------------------------------------------------------------------------
package tbpx_pkg;

  localparam int unsigned MAX_KEY_BYTES    = 32;
  localparam logic [7:0]  UNENCRYPTED_MASK = 8'h01;
  localparam int unsigned PAD_BYTES        = 16;

  // configuration register indexes
  localparam logic [2:0] CFG_KEY0   = 3'd0;
  localparam logic [2:0] CFG_KEY1   = 3'd1;
  localparam logic [2:0] CFG_KEY2   = 3'd2;
  localparam logic [2:0] CFG_KEY3   = 3'd3;
  localparam logic [2:0] CFG_KEYLEN = 3'd4;

  // MD5 initial chaining values
  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hefcdab89;
  localparam logic [31:0] IV_C = 32'h98badcfe;
  localparam logic [31:0] IV_D = 32'h10325476;

  // what the back end must do for a word
  typedef enum logic [1:0] {
    KIND_PASS  = 2'd0,   // no key: pass through
    KIND_FRESH = 2'd1,   // start a new pad chain
    KIND_CHAIN = 2'd2,   // chain next pad from current one
    KIND_USE   = 2'd3    // use the current pad
  } kind_t;

  typedef struct packed {
    logic [31:0] sid;
    logic [7:0]  ver;
    logic [7:0]  seq;
    logic [7:0]  flags;
    logic [7:0]  body;
    logic        last;
    kind_t       kind;
    logic [3:0]  pos;
  } item_t;

  // request from the back end to the hash unit
  typedef struct packed {
    logic        start;
    logic        chained;
    logic [31:0] sid;
    logic [7:0]  ver;
    logic [7:0]  seq;
  } hash_req_t;

  function automatic logic [31:0] md5_k(input logic [5:0] r);
    logic [31:0] k;
    case (r)
      6'd0:  k = 32'hd76aa478; 6'd1:  k = 32'he8c7b756; 6'd2:  k = 32'h242070db;
      6'd3:  k = 32'hc1bdceee; 6'd4:  k = 32'hf57c0faf; 6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613; 6'd7:  k = 32'hfd469501; 6'd8:  k = 32'h698098d8;
      6'd9:  k = 32'h8b44f7af; 6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
      6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
      6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
      6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
      6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
      6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
      6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
      6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
      6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
      default: k = 32'heb86d391;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] md5_s(input logic [5:0] r);
    logic [4:0] s;
    case ({r[5:4], r[1:0]})
      4'd0:  s = 5'd7;  4'd1:  s = 5'd12; 4'd2:  s = 5'd17; 4'd3:  s = 5'd22;
      4'd4:  s = 5'd5;  4'd5:  s = 5'd9;  4'd6:  s = 5'd14; 4'd7:  s = 5'd20;
      4'd8:  s = 5'd4;  4'd9:  s = 5'd11; 4'd10: s = 5'd16; 4'd11: s = 5'd23;
      4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15;
      default: s = 5'd21;
    endcase
    return s;
  endfunction

  // message word index for a round
  function automatic logic [3:0] md5_g(input logic [5:0] r);
    logic [3:0] g;
    case (r[5:4])
      2'd0:    g = r[3:0];
      2'd1:    g = 4'(r[3:0] * 4'd5 + 4'd1);
      2'd2:    g = 4'(r[3:0] * 4'd3 + 4'd5);
      default: g = 4'(r[3:0] * 4'd7);
    endcase
    return g;
  endfunction

endpackage

[sv/tbpx_front.sv]
// ---------------------------------------------------------------------------
// tbpx_front
// Accepts input words, tracks pad position, tags each word and queues it.
// ---------------------------------------------------------------------------
module tbpx_front import tbpx_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [5:0]  key_len,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // sid[31:0], ver[39:32], seq[47:40], flags[55:48], body[63:56]
  input  logic        in_tuser,   // first of body
  input  logic        in_tlast,
  output logic        q_valid,
  output item_t       q_item,
  input  logic        q_pop
);

  item_t       fifo_r [2];
  logic        wr_ptr_r, rd_ptr_r;
  logic [1:0]  count_r;
  logic [3:0]  pos_r, pos_nxt;
  logic        pad_valid_r, pad_valid_nxt;
  logic        push;
  item_t       item;

  assign in_tready = (count_r != 2'd2);
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (count_r != 2'd0);
  assign q_item    = fifo_r[rd_ptr_r];

  // classify the incoming word against the running pad position
  always_comb begin
    item.sid   = in_tdata[31:0];
    item.ver   = in_tdata[39:32];
    item.seq   = in_tdata[47:40];
    item.flags = in_tdata[55:48];
    item.body  = in_tdata[63:56];
    item.last  = in_tlast;
    item.pos   = pos_r;
    pos_nxt       = pos_r;
    pad_valid_nxt = pad_valid_r;
    if (key_len == 6'd0) begin
      item.kind = KIND_PASS;
    end else begin
      if (in_tuser || !pad_valid_r) begin
        item.kind = KIND_FRESH;
        item.pos  = 4'd0;
      end else if (pos_r == 4'd0) begin
        item.kind = KIND_CHAIN;
      end else begin
        item.kind = KIND_USE;
      end
      if (in_tlast) begin
        pos_nxt       = 4'd0;
        pad_valid_nxt = 1'b0;
      end else begin
        pos_nxt       = item.pos + 4'd1;
        pad_valid_nxt = 1'b1;
      end
    end
  end

  // hold queue pointers and pad tracking
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r    <= 1'b0;
      rd_ptr_r    <= 1'b0;
      count_r     <= 2'd0;
      pos_r       <= 4'd0;
      pad_valid_r <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr_r    <= ~wr_ptr_r;
        pos_r       <= pos_nxt;
        pad_valid_r <= pad_valid_nxt;
      end
      if (q_pop) rd_ptr_r <= ~rd_ptr_r;
      count_r <= count_r + {1'b0, push} - {1'b0, q_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) fifo_r[wr_ptr_r] <= item;
  end

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid) else $error("pop from empty queue");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != 2'd3) else $error("queue count overflow");
  a_pos_reset_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    push && in_tlast && key_len != 6'd0 |=> pos_r == 4'd0 && !pad_valid_r)
    else $error("last did not clear pad");

endmodule

[sv/tbpx_md5.sv]
// ---------------------------------------------------------------------------
// tbpx_md5
// Single-block MD5 unit, one round per cycle, digest returned as a pad.
// ---------------------------------------------------------------------------
module tbpx_md5 import tbpx_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  hash_req_t    req,
  input  logic [5:0]   key_len,   // saturated
  input  logic [255:0] key,
  input  logic [127:0] pad,
  output logic         busy,
  output logic         done,
  output logic [127:0] digest
);

  logic [511:0] blk, blk_r;
  logic [31:0]  a_r, b_r, c_r, d_r;
  logic [5:0]   rnd_r;
  logic         run_r, fin_r, done_r;
  logic [31:0]  f, m, sum, rot;
  logic [63:0]  dbl;
  logic [15:0]  nbits;

  // lay out the padded message block, byte j at blk[8j +: 8]
  always_comb begin
    int L, e, j;
    L = int'(key_len);
    e = 6 + L + (req.chained ? 16 : 0);
    nbits = 16'(e * 8);
    for (j = 0; j < 64; j++) begin
      if (j < 4)                     blk[8*j +: 8] = req.sid[8*(3-j) +: 8];
      else if (j < 4 + L)            blk[8*j +: 8] = key[8*(35-j) +: 8];
      else if (j == 4 + L)           blk[8*j +: 8] = req.ver;
      else if (j == 5 + L)           blk[8*j +: 8] = req.seq;
      else if (j < e)                blk[8*j +: 8] = pad[8*(21+L-j) +: 8];
      else if (j == e)               blk[8*j +: 8] = 8'h80;
      else if (j == 56)              blk[8*j +: 8] = nbits[7:0];
      else if (j == 57)              blk[8*j +: 8] = nbits[15:8];
      else                           blk[8*j +: 8] = 8'h00;
    end
  end

  // one round of the compression function
  always_comb begin
    case (rnd_r[5:4])
      2'd0:    f = (b_r & c_r) | (~b_r & d_r);
      2'd1:    f = (d_r & b_r) | (~d_r & c_r);
      2'd2:    f = b_r ^ c_r ^ d_r;
      default: f = c_r ^ (b_r | ~d_r);
    endcase
    m   = blk_r[32*md5_g(rnd_r) +: 32];
    sum = a_r + f + md5_k(rnd_r) + m;
    dbl = {sum, sum} << md5_s(rnd_r);
    rot = dbl[63:32];
  end

  assign busy   = run_r || fin_r;
  assign done   = done_r;

  // advance rounds, then fold in the chaining values
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
      rnd_r  <= 6'd0;
    end else begin
      done_r <= 1'b0;
      if (req.start && !busy) begin
        run_r <= 1'b1;
        rnd_r <= 6'd0;
      end else if (run_r) begin
        rnd_r <= rnd_r + 6'd1;
        if (rnd_r == 6'd63) begin
          run_r <= 1'b0;
          fin_r <= 1'b1;
        end
      end else if (fin_r) begin
        fin_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    logic [31:0] fa, fb, fc, fd;
    fa = a_r + IV_A;
    fb = b_r + IV_B;
    fc = c_r + IV_C;
    fd = d_r + IV_D;
    if (req.start && !busy) begin
      blk_r <= blk;
      a_r   <= IV_A;
      b_r   <= IV_B;
      c_r   <= IV_C;
      d_r   <= IV_D;
    end else if (run_r) begin
      a_r <= d_r;
      d_r <= c_r;
      c_r <= b_r;
      b_r <= b_r + rot;
    end else if (fin_r) begin
      digest <= {fa[7:0], fa[15:8], fa[23:16], fa[31:24],
                 fb[7:0], fb[15:8], fb[23:16], fb[31:24],
                 fc[7:0], fc[15:8], fc[23:16], fc[31:24],
                 fd[7:0], fd[15:8], fd[23:16], fd[31:24]};
    end
  end

  a_done_after_fin: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(fin_r)) else $error("digest done without finish");
  a_run_fin_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(run_r && fin_r)) else $error("round and finish overlap");

endmodule

[sv/tbpx_back.sv]
// ---------------------------------------------------------------------------
// tbpx_back
// Runs the hash when a word needs a new pad, XORs keyed bytes with the pad, drives the output.
// ---------------------------------------------------------------------------
module tbpx_back import tbpx_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic [5:0]   key_len,
  input  logic [255:0] key,
  input  logic         q_valid,
  input  item_t        q_item,
  output logic         q_pop,
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [15:0]  out_tdata,   // byte_out[7:0], flags_out[15:8]
  output logic         out_tlast
);

  typedef enum logic {S_IDLE, S_HASH} state_t;

  state_t       state_r;
  logic         hashed_r;
  logic [127:0] pad_r;
  logic         out_valid_r, out_last_r;
  logic [7:0]   out_byte_r, out_flags_r;
  logic [5:0]   klen_sat;
  logic         need, out_free, emit;
  hash_req_t    req;
  logic         h_busy, h_done;
  logic [127:0] h_digest;
  logic [7:0]   pad_byte;

  assign klen_sat = (key_len > 6'(MAX_KEY_BYTES)) ? 6'(MAX_KEY_BYTES) : key_len;
  assign need     = (q_item.kind == KIND_FRESH) || (q_item.kind == KIND_CHAIN);
  assign out_free = !out_valid_r || out_tready;
  assign emit     = q_valid && (!need || hashed_r) && out_free;
  assign q_pop    = emit;
  assign pad_byte = pad_r[{~q_item.pos, 3'b000} +: 8];

  assign req.start   = (state_r == S_IDLE) && q_valid && need && !hashed_r;
  assign req.chained = (q_item.kind == KIND_CHAIN);
  assign req.sid     = q_item.sid;
  assign req.ver     = q_item.ver;
  assign req.seq     = q_item.seq;

  tbpx_md5 u_md5 (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (req),
    .key_len (klen_sat),
    .key     (key),
    .pad     (pad_r),
    .busy    (h_busy),
    .done    (h_done),
    .digest  (h_digest)
  );

  // sequence hashing and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      hashed_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: if (req.start) state_r <= S_HASH;
        S_HASH: if (h_done) begin
          state_r  <= S_IDLE;
          hashed_r <= 1'b1;
        end
        default: state_r <= S_IDLE;
      endcase
      if (emit) begin
        hashed_r    <= 1'b0;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // pad and result payload
  always_ff @(posedge clk) begin
    if (h_done) pad_r <= h_digest;
    if (emit) begin
      out_last_r <= q_item.last;
      if (q_item.kind == KIND_PASS) begin
        out_byte_r  <= q_item.body;
        out_flags_r <= q_item.flags;
      end else begin
        out_byte_r  <= q_item.body ^ pad_byte;
        out_flags_r <= q_item.last ? (q_item.flags ^ UNENCRYPTED_MASK) : q_item.flags;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_flags_r, out_byte_r};
  assign out_tlast  = out_last_r;

  a_emit_has_pad: assert property (@(posedge clk) disable iff (!rst_n)
    emit && need |-> hashed_r) else $error("word sent before its pad");
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !h_busy) else $error("hash started while busy");
  a_done_in_hash: assert property (@(posedge clk) disable iff (!rst_n)
    h_done |-> state_r == S_HASH) else $error("unexpected digest");

endmodule

[sv/tacacs_body_pad_xor.sv]
// ---------------------------------------------------------------------------
// tacacs_body_pad_xor
// Body obfuscation with the MD5 pseudo-pad chain, one byte per word.
// ---------------------------------------------------------------------------
// Usage:
//   in_*  : one body byte per word with the packet header fields; in_tuser
//           marks the first byte of a body, in_tlast the final one.
//   out_* : the XORed byte and the flags (unencrypted bit toggled on the
//           last byte when a key is set); out_tlast copies the last mark.
//   cfg_* : register writes (key words 0..3, key length at index 4); the
//           user must make them only while no word is in flight, which
//           the block does not enforce. cfg_ready is always high.
// A word whose pad is current passes through the queue and the output
//   register; a word that opens a pad first waits for one MD5 compression
//   (a load step, 64 rounds at one round per cycle, a finish step and a
//   step to hand the pad to the back end). One pad serves 16 bytes; with
//   key length zero the block passes one byte per cycle while the receiver
//   holds out_tready high.
// Reset clears the queue, the pad tracking and the key registers. When the
//   receiver stalls, the output register holds and the two-entry queue
//   fills before in_tready drops.
// ---------------------------------------------------------------------------
module tacacs_body_pad_xor import tbpx_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // session_ident, proto_version, sequence_number,
                                  // flags_in, body_byte
  input  logic        in_tuser,   // first_of_body
  input  logic        in_tlast,   // last_of_body
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // byte_out, flags_out
  output logic        out_tlast,  // last_out
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  logic [63:0] key_r [4];
  logic [5:0]  key_len_r;
  logic        q_valid, q_pop;
  item_t       q_item;

  assign cfg_ready = 1'b1;

  // capture configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r[0]  <= 64'd0;
      key_r[1]  <= 64'd0;
      key_r[2]  <= 64'd0;
      key_r[3]  <= 64'd0;
      key_len_r <= 6'd0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_KEY0:   key_r[0]  <= cfg_data;
        CFG_KEY1:   key_r[1]  <= cfg_data;
        CFG_KEY2:   key_r[2]  <= cfg_data;
        CFG_KEY3:   key_r[3]  <= cfg_data;
        CFG_KEYLEN: key_len_r <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  tbpx_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .key_len   (key_len_r),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop)
  );

  tbpx_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .key_len    (key_len_r),
    .key        ({key_r[0], key_r[1], key_r[2], key_r[3]}),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
